/* rtl/core/bpp_pkg.sv */
// breath profile pidf controller: shared types, codes and constants
// no dependencies; compiled first
`timescale 1ns / 1ps

package bpp_pkg;

  // derivative filter weights in q0.8: 0.7 and 0.3
  localparam int ALPHA_Q8 = 179;
  localparam int BETA_Q8  = 77;

  // shared divider widths
  localparam int DIV_W = 24;
  localparam int DVS_W = 16;

  typedef enum logic [2:0] {
    CFG_PROFILE_PRESSURES = 3'd0,
    CFG_RAMP_TIMES        = 3'd1,
    CFG_HOLD_TIMES        = 3'd2,
    CFG_GAINS_FF_P        = 3'd3,
    CFG_GAINS_I_D         = 3'd4,
    CFG_INTEGRAL_LIMITS   = 3'd5,
    CFG_OUTPUT_LIMITS     = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FLAT,
    OP_MUL_RISE,
    OP_DIV_RISE,
    OP_SP_RISE,
    OP_MUL_FALL_A,
    OP_MUL_FALL_B,
    OP_DIV_FALL,
    OP_SP_FALL,
    OP_ERR,
    OP_FD,
    OP_DIV_AW,
    OP_AW,
    OP_MUL_KF,
    OP_MUL_KP,
    OP_MUL_KI,
    OP_MUL_KD,
    OP_SUM,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } bpp_cmd_t;

  typedef struct packed {
    logic seg_rise;
    logic seg_fall;
    logic aw_needed;
    logic div_busy;
    logic out_free;
  } bpp_status_t;

endpackage

/* rtl/core/bpp_channels.sv */
// valid/ready channel interfaces for control ticks and drive results
// no dependencies
`timescale 1ns / 1ps

interface bpp_sample_if;
  logic               valid;
  logic               ready;
  logic [31:0]        time_ms;
  logic               enable;
  logic signed [15:0] measured_pressure;

  modport source (output valid, time_ms, enable, measured_pressure, input ready);
  modport sink (input valid, time_ms, enable, measured_pressure, output ready);
endinterface

interface bpp_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive_output;
  logic [7:0]         pressure_setpoint;

  modport source (output valid, drive_output, pressure_setpoint, input ready);
  modport sink (input valid, drive_output, pressure_setpoint, output ready);
endinterface

/* rtl/core/bpp_div.sv */
// shared restoring divider, one quotient bit per cycle
// uses bpp_pkg for widths
`timescale 1ns / 1ps

module bpp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bpp_pkg::DIV_W-1:0] dividend,
  input  logic [bpp_pkg::DVS_W-1:0] divisor,
  output logic                      busy,
  output logic [bpp_pkg::DIV_W-1:0] quotient
);
  import bpp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  assign rem_sh   = {rem, dvd[DIV_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
      dvd <= {dvd[DIV_W-2:0], fits};
    end
  end

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == '0 && !start) |=> !busy)
    else $error("divider ran past its last step");
  a_count_run: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt != '0 && !start) |=> (busy && cnt == $past(cnt) - 1'b1))
    else $error("divider count skipped");
`endif

endmodule

/* rtl/core/bpp_datapath.sv */
// configuration registers, loop state, shared multiplier and divider
// uses bpp_pkg and bpp_div
`timescale 1ns / 1ps

module bpp_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic [31:0]          time_ms,
  input  logic                 enable,
  input  logic signed [15:0]   measured_pressure,
  input  bpp_pkg::bpp_cmd_t    cmd,
  output bpp_pkg::bpp_status_t sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic signed [15:0]   drive_output,
  output logic [7:0]           pressure_setpoint
);
  import bpp_pkg::*;

  // configuration
  logic [15:0] pressures;
  logic [31:0] ramp_times, hold_times, gains_fp, gains_id, int_limits, out_limits;

  logic [7:0]  peep, pip;
  logic [15:0] r, d, h, l, kf, kp, ki, kd, win, aw;
  logic signed [15:0] omin, omax;

  // loop state
  logic [31:0]        start_time;
  logic               was_en;
  logic signed [31:0] integ;
  logic signed [19:0] fd;
  logic signed [17:0] prev_err;

  // per-item working registers
  logic signed [15:0] meas;
  logic [31:0]        e;
  logic [7:0]         sp;
  logic signed [17:0] err;
  logic signed [31:0] integ_w;
  logic signed [50:0] acc;
  logic signed [49:0] prod;

  logic [16:0] rh;
  logic [17:0] rhd, total;
  logic        seg_rise, seg_hold, seg_fall, seg_end;
  logic [31:0] e2_full;
  logic [15:0] e2;
  logic        pip_ge;
  logic [7:0]  mag;
  logic [31:0] start_eff;

  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] product;

  logic              div_start, div_busy;
  logic [DIV_W-1:0]  div_dividend, div_quot;
  logic [DVS_W-1:0]  div_divisor;
  logic signed [50:0] fall_num;

  logic [17:0]        err_abs;
  logic               inwin;
  logic signed [18:0] diff;
  logic signed [27:0] fd_sum;
  logic signed [32:0] integ_sum;
  logic signed [31:0] integ_sat;
  logic [31:0]        integ_mag;
  logic [31:0]        lim;
  logic signed [50:0] rnd;
  logic signed [42:0] rnd_q, clamp_hi, clamp_lo;

  assign peep = pressures[7:0];
  assign pip  = pressures[15:8];
  assign r    = ramp_times[15:0];
  assign d    = ramp_times[31:16];
  assign h    = hold_times[15:0];
  assign l    = hold_times[31:16];
  assign kf   = gains_fp[15:0];
  assign kp   = gains_fp[31:16];
  assign ki   = gains_id[15:0];
  assign kd   = gains_id[31:16];
  assign win  = int_limits[15:0];
  assign aw   = int_limits[31:16];
  assign omin = out_limits[15:0];
  assign omax = out_limits[31:16];

  // profile segment bounds
  assign rh       = {1'b0, r} + {1'b0, h};
  assign rhd      = {1'b0, rh} + {2'b0, d};
  assign total    = rhd + {2'b0, l};
  assign seg_rise = e < {16'b0, r};
  assign seg_hold = e < {15'b0, rh};
  assign seg_fall = e < {14'b0, rhd};
  assign seg_end  = e >= {14'b0, total};
  assign e2_full  = e - {15'b0, rh};
  assign e2       = e2_full[15:0];
  assign pip_ge   = pip >= peep;
  assign mag      = pip_ge ? pip - peep : peep - pip;
  assign start_eff = (!was_en && enable) ? time_ms : start_time;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_RISE: begin
        mul_a = {9'b0, mag};
        mul_b = {16'b0, e[16:0]};
      end
      OP_MUL_FALL_A: begin
        mul_a = {9'b0, pip};
        mul_b = {17'b0, d - e2};
      end
      OP_MUL_FALL_B: begin
        mul_a = {9'b0, peep};
        mul_b = {17'b0, e2};
      end
      OP_MUL_KF: begin
        mul_a = {1'b0, kf};
        mul_b = {25'b0, sp};
      end
      OP_MUL_KP: begin
        mul_a = {1'b0, kp};
        mul_b = {{15{err[17]}}, err};
      end
      OP_MUL_KI: begin
        mul_a = {1'b0, ki};
        mul_b = {integ_w[31], integ_w};
      end
      OP_MUL_KD: begin
        mul_a = {1'b0, kd};
        mul_b = {{13{fd[19]}}, fd};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product  = mul_a * mul_b;
  assign fall_num = acc + {prod[49], prod};

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd.op)
      OP_DIV_RISE: begin
        div_start    = 1'b1;
        div_dividend = prod[DIV_W-1:0];
        div_divisor  = r;
      end
      OP_DIV_FALL: begin
        div_start    = 1'b1;
        div_dividend = fall_num[DIV_W-1:0];
        div_divisor  = d;
      end
      OP_DIV_AW: begin
        div_start    = 1'b1;
        div_dividend = {aw, 8'b0};
        div_divisor  = ki;
      end
      default: begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  bpp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // error window, filter and integral
  assign err_abs   = err[17] ? 18'(-err) : err;
  assign inwin     = err_abs < {2'b0, win};
  assign diff      = {err[17], err} - {prev_err[17], prev_err};
  assign fd_sum    = 28'(diff) * 28'(ALPHA_Q8) + 28'(fd) * 28'(BETA_Q8) + 28'sd128;
  assign integ_sum = {integ[31], integ} + 33'(err);
  assign integ_sat = (integ_sum[32] != integ_sum[31]) ?
                     (integ_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : integ_sum[31:0];
  assign integ_mag = integ_w[31] ? 32'(-integ_w) : 32'(integ_w);
  assign lim       = {8'b0, div_quot};

  // rounding and clamp
  assign rnd      = acc + 51'sd128;
  assign rnd_q    = rnd[50:8];
  assign clamp_hi = (rnd_q > 43'(omax)) ? 43'(omax) : rnd_q;
  assign clamp_lo = (clamp_hi < 43'(omin)) ? 43'(omin) : clamp_hi;

  assign sts.seg_rise  = seg_rise;
  assign sts.seg_fall  = !seg_hold && seg_fall;
  assign sts.aw_needed = inwin && (ki != '0);
  assign sts.div_busy  = div_busy;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressures  <= '0;
      ramp_times <= '0;
      hold_times <= '0;
      gains_fp   <= '0;
      gains_id   <= '0;
      int_limits <= '0;
      out_limits <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROFILE_PRESSURES: pressures  <= cfg_wdata[15:0];
        CFG_RAMP_TIMES:        ramp_times <= cfg_wdata;
        CFG_HOLD_TIMES:        hold_times <= cfg_wdata;
        CFG_GAINS_FF_P:        gains_fp   <= cfg_wdata;
        CFG_GAINS_I_D:         gains_id   <= cfg_wdata;
        CFG_INTEGRAL_LIMITS:   int_limits <= cfg_wdata;
        CFG_OUTPUT_LIMITS:     out_limits <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      was_en     <= 1'b0;
      integ      <= '0;
      fd         <= '0;
      prev_err   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && cmd.op != OP_OUT) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          start_time <= start_eff;
          was_en     <= enable;
        end
        OP_FLAT: begin
          // period over: move the breath start on by one period
          if (seg_end) begin
            start_time <= start_time + {14'b0, total};
          end
        end
        OP_FD: fd <= fd_sum[27:8];
        OP_OUT: begin
          integ     <= integ_w;
          prev_err  <= err;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        meas <= measured_pressure;
        e    <= time_ms - start_eff;
      end
      OP_FLAT:       sp <= seg_hold ? pip : peep;
      OP_MUL_RISE:   prod <= product;
      OP_SP_RISE:    sp <= pip_ge ? peep + div_quot[7:0] : peep - div_quot[7:0];
      OP_MUL_FALL_A: prod <= product;
      OP_MUL_FALL_B: begin
        acc  <= {prod[49], prod};
        prod <= product;
      end
      OP_SP_FALL:    sp <= div_quot[7:0];
      OP_ERR:        err <= {2'b0, sp, 8'b0} - {{2{meas[15]}}, meas};
      OP_FD:         integ_w <= inwin ? integ_sat : '0;
      OP_AW: begin
        // anti-windup: cap the integral at aw*256/ki in magnitude
        if (integ_mag > lim) begin
          integ_w <= integ_w[31] ? -$signed(lim) : $signed(lim);
        end
      end
      OP_MUL_KF:     prod <= product;
      OP_MUL_KP: begin
        acc  <= {prod[42:0], 8'b0};
        prod <= product;
      end
      OP_MUL_KI, OP_MUL_KD: begin
        acc  <= acc + {prod[49], prod};
        prod <= product;
      end
      OP_SUM:        acc <= acc + {prod[49], prod};
      OP_OUT: begin
        drive_output      <= clamp_lo[15:0];
        pressure_setpoint <= sp;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/bpp_ctrl.sv */
// sequencing state machine: steps the datapath through one control tick
// uses bpp_pkg
`timescale 1ns / 1ps

module bpp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bpp_pkg::bpp_status_t sts,
  output bpp_pkg::bpp_cmd_t    cmd
);
  import bpp_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE       = 20'h00001,
    ST_SEG        = 20'h00002,
    ST_RISE_DIV   = 20'h00004,
    ST_RISE_WAIT  = 20'h00008,
    ST_RISE_SP    = 20'h00010,
    ST_FALL_MUL_B = 20'h00020,
    ST_FALL_DIV   = 20'h00040,
    ST_FALL_WAIT  = 20'h00080,
    ST_FALL_SP    = 20'h00100,
    ST_ERR        = 20'h00200,
    ST_FD         = 20'h00400,
    ST_AW_DIV     = 20'h00800,
    ST_AW_WAIT    = 20'h01000,
    ST_AW         = 20'h02000,
    ST_MKF        = 20'h04000,
    ST_MKP        = 20'h08000,
    ST_MKI        = 20'h10000,
    ST_MKD        = 20'h20000,
    ST_SUM        = 20'h40000,
    ST_OUT        = 20'h80000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_SEG;
        end
      end
      ST_SEG: begin
        if (sts.seg_rise) begin
          cmd.op     = OP_MUL_RISE;
          state_next = ST_RISE_DIV;
        end else if (sts.seg_fall) begin
          cmd.op     = OP_MUL_FALL_A;
          state_next = ST_FALL_MUL_B;
        end else begin
          cmd.op     = OP_FLAT;
          state_next = ST_ERR;
        end
      end
      ST_RISE_DIV: begin
        cmd.op     = OP_DIV_RISE;
        state_next = ST_RISE_WAIT;
      end
      ST_RISE_WAIT: if (!sts.div_busy) state_next = ST_RISE_SP;
      ST_RISE_SP: begin
        cmd.op     = OP_SP_RISE;
        state_next = ST_ERR;
      end
      ST_FALL_MUL_B: begin
        cmd.op     = OP_MUL_FALL_B;
        state_next = ST_FALL_DIV;
      end
      ST_FALL_DIV: begin
        cmd.op     = OP_DIV_FALL;
        state_next = ST_FALL_WAIT;
      end
      ST_FALL_WAIT: if (!sts.div_busy) state_next = ST_FALL_SP;
      ST_FALL_SP: begin
        cmd.op     = OP_SP_FALL;
        state_next = ST_ERR;
      end
      ST_ERR: begin
        cmd.op     = OP_ERR;
        state_next = ST_FD;
      end
      ST_FD: begin
        cmd.op     = OP_FD;
        state_next = sts.aw_needed ? ST_AW_DIV : ST_MKF;
      end
      ST_AW_DIV: begin
        cmd.op     = OP_DIV_AW;
        state_next = ST_AW_WAIT;
      end
      ST_AW_WAIT: if (!sts.div_busy) state_next = ST_AW;
      ST_AW: begin
        cmd.op     = OP_AW;
        state_next = ST_MKF;
      end
      ST_MKF: begin
        cmd.op     = OP_MUL_KF;
        state_next = ST_MKP;
      end
      ST_MKP: begin
        cmd.op     = OP_MUL_KP;
        state_next = ST_MKI;
      end
      ST_MKI: begin
        cmd.op     = OP_MUL_KI;
        state_next = ST_MKD;
      end
      ST_MKD: begin
        cmd.op     = OP_MUL_KD;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op     = OP_SUM;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait for the result register to drain
        if (sts.out_free) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_accept_seg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> state == ST_SEG)
    else $error("accepted item did not enter the profile step");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |-> sts.out_free)
    else $error("result written over a pending item");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_RISE || cmd.op == OP_DIV_FALL || cmd.op == OP_DIV_AW)
    |-> !sts.div_busy)
    else $error("divider restarted while busy");
`endif

endmodule

/* rtl/core/breath_profile_pidf_controller_core.sv */
// channel   | dir | payload
// sample    | in  | time_ms[31:0], enable, measured_pressure[15:0] signed q7.8
// result    | out | drive_output[15:0] signed q7.8, pressure_setpoint[7:0]
// cfg_*     | in  | cfg_we, cfg_index[2:0], cfg_wdata[31:0], seven registers
//
// one item at a time: an accepted item steps through the profile, error,
// filter, gain and output steps before the next item can be taken; a rising
// or falling ramp and anti-windup each add a wait on the shared divider,
// which resolves one quotient bit per cycle.
// reset clears configuration and loop state; a new item is taken once the
// previous result sits in the output register, which holds under stall.
`timescale 1ns / 1ps

module breath_profile_pidf_controller_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  bpp_sample_if.sink          sample,
  bpp_result_if.source        result
);
  import bpp_pkg::*;

  bpp_cmd_t    cmd;
  bpp_status_t sts;

  bpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpp_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .time_ms           (sample.time_ms),
    .enable            (sample.enable),
    .measured_pressure (sample.measured_pressure),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (result.ready),
    .out_valid         (result.valid),
    .drive_output      (result.drive_output),
    .pressure_setpoint (result.pressure_setpoint)
  );

endmodule

/* tb/sv/breath_profile_pidf_controller_core_tb.sv */
// testbench for the breath profile pidf controller core: drives control ticks,
// predicts drive and set point per tick, checks every result in order
// depends on bpp_pkg, bpp_channels and the core rtl
`timescale 1ns / 1ps

module breath_profile_pidf_controller_core_tb;
  import bpp_pkg::*;

  typedef struct {
    logic signed [15:0] drive;
    logic [7:0]         setpoint;
  } drive_item_t;

  // loop predictor with its own register and state copies
  class drive_scoreboard;
    logic [31:0] regs [7];
    logic [31:0] start_ms;
    bit          was_on;
    longint      integ, filt_d, prev_err;
    drive_item_t pending [$];
    int          errors;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      start_ms = '0; was_on = 0; integ = 0; filt_d = 0; prev_err = 0;
      pending.delete(); errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] v);
      regs[idx] = (idx == CFG_PROFILE_PRESSURES) ? {16'h0, v[15:0]} : v;
    endfunction

    function longint fdiv256(longint x);
      return (x >= 0) ? x / 256 : -((-x + 255) / 256);
    endfunction

    function logic [7:0] setpoint_at(logic [31:0] now);
      logic [31:0] lo, hi, r, d, h, l, e, mag, off;
      longint e2, num;
      lo = regs[0][7:0]; hi = regs[0][15:8];
      r = regs[1][15:0]; d = regs[1][31:16];
      h = regs[2][15:0]; l = regs[2][31:16];
      e = now - start_ms;
      if (e < r) begin
        mag = (hi >= lo) ? hi - lo : lo - hi;
        off = (e * mag) / r;
        return 8'((hi >= lo) ? lo + off : lo - off);
      end
      if (e < r + h) return hi[7:0];
      if (e < r + h + d) begin
        e2 = longint'(e - (r + h));
        num = longint'(hi) * longint'(d) + e2 * (longint'(lo) - longint'(hi));
        return 8'(num / longint'(d));
      end
      if (e >= r + h + d + l) start_ms = start_ms + r + h + d + l;
      return lo[7:0];
    endfunction

    function void note_tick(logic [31:0] now, bit en, logic signed [15:0] meas);
      longint kf, kp, ki, kd, win, aw, omin, omax, err, fd, it, mag, lim, s, o;
      logic [7:0] sp;
      drive_item_t x;
      kf = regs[3][15:0]; kp = regs[3][31:16];
      ki = regs[4][15:0]; kd = regs[4][31:16];
      win = regs[5][15:0]; aw = regs[5][31:16];
      omin = $signed(regs[6][15:0]); omax = $signed(regs[6][31:16]);
      if (!was_on && en) start_ms = now;
      sp = setpoint_at(now);
      err = longint'(sp) * 256 - longint'(meas);
      fd = fdiv256(179 * (err - prev_err) + 77 * filt_d + 128);
      filt_d = fd;
      it = integ;
      if (((err < 0) ? -err : err) < win) begin
        it += err;
        if (it > 64'sd2147483647) it = 64'sd2147483647;
        if (it < -64'sd2147483648) it = -64'sd2147483648;
        mag = (it < 0) ? -it : it;
        if (mag * ki > aw * 256) begin
          lim = (aw * 256) / ki;
          it = (it < 0) ? -lim : lim;
        end
      end else begin
        it = 0;
      end
      integ = it;
      s = kf * sp * 256 + kp * err + ki * it + kd * fd;
      o = fdiv256(s + 128);
      if (o > omax) o = omax;
      if (o < omin) o = omin;
      prev_err = err;
      was_on = en;
      x.drive = o[15:0];
      x.setpoint = sp;
      pending.push_back(x);
    endfunction

    function void check_result(logic signed [15:0] drive, logic [7:0] sp);
      drive_item_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item drive %0d sp %0d", $time, drive, sp);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (x.drive !== drive) begin
        $display("%0t: drive expected %0d actual %0d", $time, x.drive, drive);
        errors++;
      end
      if (x.setpoint !== sp) begin
        $display("%0t: setpoint expected %0d actual %0d", $time, x.setpoint, sp);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  bit          hold_off = 0;
  bit          rx_took = 0;
  int          rx_wait = 0;
  logic [31:0] clock_ms = '0;

  bpp_sample_if sample();
  bpp_result_if result();

  breath_profile_pidf_controller_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .sample(sample), .result(result)
  );

  drive_scoreboard sb = new();

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  task automatic write_cfg(cfg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic send_tick(logic [31:0] now, bit en, logic signed [15:0] meas);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(negedge clk);
      sample.valid <= 0;
    end
    @(negedge clk);
    sample.valid <= 1; sample.time_ms <= now;
    sample.enable <= en; sample.measured_pressure <= meas;
    do @(posedge clk); while (!sample.ready);
    sb.note_tick(now, en, meas);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    sample.valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // time advances mostly by one ms, with occasional jumps and wraps
  task automatic random_ticks(int n, bit measure_noise);
    logic signed [15:0] meas;
    bit en;
    repeat (n) begin
      case ($urandom_range(0, 19))
        0: clock_ms = $urandom;
        1: clock_ms = clock_ms + $urandom_range(2, 500);
        default: clock_ms = clock_ms + 1;
      endcase
      en = ($urandom_range(0, 15) != 0);
      if (measure_noise) meas = 16'($urandom);
      else meas = $signed(16'($urandom_range(0, 12000))) +
                  $signed(16'($urandom_range(0, 400))) - 16'sd200;
      send_tick(clock_ms, en, meas);
    end
  endtask

  task automatic random_config(bit tiny_ramps);
    logic [31:0] r, h;
    write_cfg(CFG_PROFILE_PRESSURES, $urandom);
    if (tiny_ramps) begin
      r = {16'($urandom_range(0, 40)), 16'($urandom_range(0, 40))};
      h = {16'($urandom_range(0, 40)), 16'($urandom_range(0, 40))};
    end else begin
      r = $urandom; h = $urandom;
    end
    write_cfg(CFG_RAMP_TIMES, r);
    write_cfg(CFG_HOLD_TIMES, h);
    write_cfg(CFG_GAINS_FF_P, $urandom);
    write_cfg(CFG_GAINS_I_D, ($urandom_range(0, 5) == 0) ? {16'($urandom), 16'h0} : $urandom);
    write_cfg(CFG_INTEGRAL_LIMITS, $urandom);
    write_cfg(CFG_OUTPUT_LIMITS, $urandom);
  endtask

  // receiver: a random wait after each item taken, plus a long hold-off on request
  always @(negedge clk) begin
    if (rx_took) rx_wait = $urandom_range(0, 3);
    if (rst || hold_off) begin
      result.ready <= 0;
    end else if (rx_wait != 0) begin
      rx_wait = rx_wait - 1;
      result.ready <= 0;
    end else begin
      result.ready <= 1;
    end
  end

  always @(posedge clk) begin
    rx_took <= !rst && result.valid && result.ready;
    if (!rst && result.valid && result.ready)
      sb.check_result(result.drive_output, result.pressure_setpoint);
  end

  initial begin
    sample.valid = 0;
    sample.time_ms = '0;
    sample.enable = 0;
    sample.measured_pressure = '0;
    sb.clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: a plain breath shape
    write_cfg(CFG_PROFILE_PRESSURES, {8'd20, 8'd5});
    write_cfg(CFG_RAMP_TIMES, {16'd4, 16'd6});
    write_cfg(CFG_HOLD_TIMES, {16'd3, 16'd2});
    write_cfg(CFG_GAINS_FF_P, {16'h0200, 16'h0080});
    write_cfg(CFG_GAINS_I_D, {16'h0100, 16'h0040});
    write_cfg(CFG_INTEGRAL_LIMITS, {16'h0400, 16'h0800});
    write_cfg(CFG_OUTPUT_LIMITS, {16'h7fff, 16'h8000});
    send_tick(32'd100, 1, 16'sd0);
    for (int i = 1; i < 18; i++) send_tick(32'd100 + i, 1, 16'sd1000);
    send_tick(32'd200, 0, 16'sh7fff);
    send_tick(32'd201, 1, -16'sd32768);
    send_tick(32'hffff_ffff, 1, 16'sd5);
    drop_valid();
    drain();

    // zero period, zero ki, min above max, full extremes
    write_cfg(CFG_PROFILE_PRESSURES, 16'hff00);
    write_cfg(CFG_RAMP_TIMES, '0);
    write_cfg(CFG_HOLD_TIMES, '0);
    write_cfg(CFG_GAINS_FF_P, 32'hffff_ffff);
    write_cfg(CFG_GAINS_I_D, 32'hffff_0000);
    write_cfg(CFG_INTEGRAL_LIMITS, 32'hffff_ffff);
    write_cfg(CFG_OUTPUT_LIMITS, 32'h8000_7fff);
    send_tick(32'd0, 1, -16'sd32768);
    send_tick(32'd1, 1, 16'sh7fff);
    send_tick(32'd2, 0, 16'sd0);
    drop_valid();
    drain();
    write_cfg(CFG_RAMP_TIMES, 32'hffff_ffff);
    write_cfg(CFG_HOLD_TIMES, 32'hffff_ffff);
    write_cfg(CFG_GAINS_I_D, 32'hffff_ffff);
    write_cfg(CFG_OUTPUT_LIMITS, 32'h7fff_8000);
    send_tick(32'd5, 1, 16'sd0);
    send_tick(32'd70000, 1, 16'sh7fff);
    send_tick(32'd140000, 1, -16'sd32768);
    drop_valid();
    drain();

    // random phases; the second runs against a long receiver stall
    for (int ph = 0; ph < 12; ph++) begin
      random_config(ph % 3 != 2);
      if (ph == 1) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      random_ticks(95, 0);
      random_ticks(8, 1);
      drop_valid();
      drain();
    end
    if (sb.errors == 0) $display("breath_profile_pidf_controller_core: match");
    else $display("breath_profile_pidf_controller_core: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("breath_profile_pidf_controller_core: mismatch");
    $finish;
  end
endmodule
